// ===== rtl/core/pet_pkg.sv =====
package pet_pkg;

    // default sizes of the table
    localparam int SLOT_COUNT_DEF = 12;
    localparam int ID_BITS_DEF    = 8;

    // width of the id field on the ports
    localparam int ID_FIELD_W = 8;

    // countdown codes
    localparam logic [15:0] CD_INACTIVE = 16'hFFFF;
    localparam logic [15:0] IVL_MAX     = 16'hFFFE;

    // operation codes
    localparam logic [2:0] OP_ACTIVATE   = 3'd0;
    localparam logic [2:0] OP_CANCEL     = 3'd1;
    localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
    localparam logic [2:0] OP_TICK       = 3'd3;
    localparam logic [2:0] OP_SERVICE    = 3'd4;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NULL      = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;
    localparam logic [2:0] ST_FIRED     = 3'd5;

    // input transaction
    typedef struct packed {
        logic [2:0]            op;
        logic [ID_FIELD_W-1:0] event_id;
        logic [15:0]           interval;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [2:0]            status;
        logic [ID_FIELD_W-1:0] fired_id;
        logic [3:0]            slot;
        logic                  last;
    } t_out_item;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd_en;
        logic eval_en;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_needed;
        logic eval_emit;
        logic hit_done;
        logic out_space;
    } t_stat;

endpackage

// ===== rtl/core/pet_controller.sv =====
module pet_controller #(
    parameter int SLOT_COUNT = pet_pkg::SLOT_COUNT_DEF,
    localparam int AddrW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pet_pkg::t_stat      i_stat,
    output pet_pkg::t_cmd       o_cmd,
    output logic [AddrW-1:0]    o_rd_addr,
    output logic [AddrW-1:0]    o_eval_idx
);

    localparam logic [AddrW-1:0] LastIdx = AddrW'(SLOT_COUNT - 1);

    pet_pkg::t_state r_state, n_state;
    logic [AddrW-1:0] r_idx, n_idx;
    logic             advance;

    // slot being evaluated moves on unless the output is blocked
    assign advance = !(i_stat.eval_emit && !i_stat.out_space);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pet_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pet_pkg::S_READ;
                end
            end
            pet_pkg::S_READ: begin
                n_state = i_stat.scan_needed ? pet_pkg::S_EVAL : pet_pkg::S_DONE;
            end
            pet_pkg::S_EVAL: begin
                if (advance) begin
                    priority if (i_stat.hit_done) begin
                        n_state = pet_pkg::S_IDLE;
                    end else if (r_idx == LastIdx) begin
                        n_state = pet_pkg::S_DONE;
                    end
                end
            end
            pet_pkg::S_DONE: begin
                if (i_stat.out_space) begin
                    n_state = pet_pkg::S_IDLE;
                end
            end
            default: n_state = pet_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_rd_addr     = '0;
        unique case (r_state)
            pet_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pet_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            pet_pkg::S_EVAL: begin
                o_cmd.eval_en = advance;
                if (advance && !i_stat.hit_done && r_idx != LastIdx) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_idx + AddrW'(1);
                end
            end
            pet_pkg::S_DONE: begin
                o_cmd.finish = i_stat.out_space;
            end
            default: ;
        endcase
    end

    assign o_eval_idx = r_idx;
    assign n_idx      = o_cmd.rd_en ? o_rd_addr : r_idx;

    // state and slot index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pet_pkg::S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // a blocked result holds the scan in place
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pet_pkg::S_EVAL && i_stat.eval_emit && !i_stat.out_space)
        |=> (r_state == pet_pkg::S_EVAL && $stable(r_idx)))
        else $error("scan moved while its result was blocked");

    // slot index never leaves the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LastIdx)
        else $error("slot index out of range");

endmodule

// ===== rtl/core/pet_datapath.sv =====
module pet_datapath #(
    parameter int SLOT_COUNT = pet_pkg::SLOT_COUNT_DEF,
    parameter int ID_BITS    = pet_pkg::ID_BITS_DEF,
    localparam int AddrW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pet_pkg::t_in_item   i_in_data,
    input  pet_pkg::t_cmd       i_cmd,
    input  logic [AddrW-1:0]    i_rd_addr,
    input  logic [AddrW-1:0]    i_eval_idx,
    output pet_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pet_pkg::t_out_item  o_out_data
);

    localparam int IdW   = (ID_BITS < pet_pkg::ID_FIELD_W) ? ID_BITS : pet_pkg::ID_FIELD_W;
    localparam int WordW = 32 + IdW;

    // slot table: countdown, reload interval, event id
    logic [WordW-1:0]      mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;

    // latched transaction
    logic [2:0]            r_op;
    logic [IdW-1:0]        r_id;
    logic [15:0]           r_ivl, n_ivl;

    // registered read port
    logic [WordW-1:0]      r_rd_word;
    logic                  r_rd_valid;

    // scan bookkeeping
    logic                  r_free_found;
    logic [AddrW-1:0]      r_free_idx;
    logic                  r_pend_valid;
    logic [IdW-1:0]        r_pend_id;
    logic [AddrW-1:0]      r_pend_slot;

    // output register
    logic                  r_out_valid;
    pet_pkg::t_out_item    r_out_data, n_out_data;

    logic [15:0]           cd, rl;
    logic [IdW-1:0]        ev;
    logic                  active, fire, hit, eval_emit, out_space, out_load;
    logic                  wr_en;
    logic [AddrW-1:0]      wr_addr;
    logic [WordW-1:0]      wr_data;
    pet_pkg::t_out_item    eval_res, fin_res;

    // interval clamp: zero runs as one, all-ones would read as inactive
    always_comb begin
        priority if (i_in_data.interval == 16'd0) begin
            n_ivl = 16'd1;
        end else if (i_in_data.interval == pet_pkg::CD_INACTIVE) begin
            n_ivl = pet_pkg::IVL_MAX;
        end else begin
            n_ivl = i_in_data.interval;
        end
    end

    // unwritten entries read as their reset contents
    assign cd     = r_rd_valid ? r_rd_word[WordW-1 -: 16] : pet_pkg::CD_INACTIVE;
    assign rl     = r_rd_valid ? r_rd_word[WordW-17 -: 16] : 16'd0;
    assign ev     = r_rd_valid ? r_rd_word[IdW-1:0] : '0;
    assign active = (cd != pet_pkg::CD_INACTIVE);

    // per-slot evaluation and table writes
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = i_eval_idx;
        wr_data   = {cd, rl, ev};
        hit       = 1'b0;
        fire      = 1'b0;
        eval_emit = 1'b0;
        eval_res  = '0;
        unique case (r_op)
            pet_pkg::OP_ACTIVATE: begin
                if (active && ev == r_id) begin
                    hit       = 1'b1;
                    eval_emit = 1'b1;
                    wr_en     = i_cmd.eval_en;
                    wr_data   = {r_ivl, r_ivl, ev};
                    eval_res  = '{status: pet_pkg::ST_REFRESHED,
                                  fired_id: pet_pkg::ID_FIELD_W'(r_id),
                                  slot: 4'(i_eval_idx), last: 1'b1};
                end
            end
            pet_pkg::OP_CANCEL: begin
                if (ev == r_id) begin
                    wr_en   = i_cmd.eval_en;
                    wr_data = {pet_pkg::CD_INACTIVE, rl, IdW'(0)};
                end
            end
            pet_pkg::OP_TICK: begin
                if (active && cd != 16'd0) begin
                    wr_en   = i_cmd.eval_en;
                    wr_data = {cd - 16'd1, rl, ev};
                end
            end
            pet_pkg::OP_SERVICE: begin
                if (cd == 16'd0) begin
                    wr_en     = i_cmd.eval_en;
                    wr_data   = {rl, rl, ev};
                    fire      = (ev != '0);
                    eval_emit = fire && r_pend_valid;
                    eval_res  = '{status: pet_pkg::ST_FIRED,
                                  fired_id: pet_pkg::ID_FIELD_W'(r_pend_id),
                                  slot: 4'(r_pend_slot), last: 1'b0};
                end
            end
            default: ;
        endcase
        // new entry goes into the first free slot at the end of the scan
        if (i_cmd.finish && r_op == pet_pkg::OP_ACTIVATE && r_id != '0 && r_free_found) begin
            wr_en   = 1'b1;
            wr_addr = r_free_idx;
            wr_data = {r_ivl, r_ivl, r_id};
        end
    end

    // final result of the transaction
    always_comb begin
        fin_res = '{status: pet_pkg::ST_DONE, fired_id: '0, slot: 4'd0, last: 1'b1};
        unique case (r_op)
            pet_pkg::OP_ACTIVATE: begin
                priority if (r_id == '0) begin
                    fin_res.status = pet_pkg::ST_NULL;
                end else if (r_free_found) begin
                    fin_res.status   = pet_pkg::ST_ADDED;
                    fin_res.fired_id = pet_pkg::ID_FIELD_W'(r_id);
                    fin_res.slot     = 4'(r_free_idx);
                end else begin
                    fin_res.status   = pet_pkg::ST_FULL;
                    fin_res.fired_id = pet_pkg::ID_FIELD_W'(r_id);
                end
            end
            pet_pkg::OP_CANCEL: begin
                fin_res.fired_id = pet_pkg::ID_FIELD_W'(r_id);
            end
            pet_pkg::OP_SERVICE: begin
                if (r_pend_valid) begin
                    fin_res.status   = pet_pkg::ST_FIRED;
                    fin_res.fired_id = pet_pkg::ID_FIELD_W'(r_pend_id);
                    fin_res.slot     = 4'(r_pend_slot);
                end
            end
            default: ;
        endcase
    end

    assign out_space  = !r_out_valid || i_out_ready;
    assign out_load   = (i_cmd.eval_en && eval_emit) || i_cmd.finish;
    assign n_out_data = i_cmd.finish ? fin_res : eval_res;

    // status back to the controller
    assign o_stat.scan_needed = (r_op == pet_pkg::OP_ACTIVATE && r_id != '0)
                             || r_op == pet_pkg::OP_CANCEL
                             || r_op == pet_pkg::OP_TICK
                             || r_op == pet_pkg::OP_SERVICE;
    assign o_stat.eval_emit   = eval_emit;
    assign o_stat.hit_done    = hit;
    assign o_stat.out_space   = out_space;

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= mem[i_rd_addr];
        end
    end

    // written flags, cleared at once by reset and cancel all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.finish && r_op == pet_pkg::OP_CANCEL_ALL) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.op;
            r_id  <= i_in_data.event_id[IdW-1:0];
            r_ivl <= n_ivl;
        end
    end

    // free slot and pending fired slot tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_found <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_free_found <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.eval_en) begin
            if (r_op == pet_pkg::OP_ACTIVATE && !active && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (r_op == pet_pkg::OP_SERVICE && fire) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_en && r_op == pet_pkg::OP_ACTIVATE && !active && !r_free_found) begin
            r_free_idx <= i_eval_idx;
        end
        if (i_cmd.eval_en && r_op == pet_pkg::OP_SERVICE && fire) begin
            r_pend_id   <= ev;
            r_pend_slot <= i_eval_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a result is only loaded when the output register can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_space)
        else $error("output register overrun");

    // a held fired slot only exists during a service scan
    a_pend_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_op == pet_pkg::OP_SERVICE))
        else $error("pending fired slot outside service");

    // cancel all leaves every slot at its reset contents
    a_cancel_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_op == pet_pkg::OP_CANCEL_ALL) |=> (r_valid == '0))
        else $error("cancel all left written slots");

endmodule

// ===== rtl/core/periodic_event_timer_table.sv =====
// Periodic event timer table: SLOT_COUNT slots, each with a countdown, a reload
// interval and an event id, scanned one slot per cycle while the output is not
// blocked, through a table memory with one read port and one write port. The
// block takes one transaction at a time. Activate, cancel, tick and service walk
// the table (an activate that finds its id already active stops at that slot),
// pausing while the output side stalls; cancel all, a null activate and unknown
// ops skip the walk. Service emits one transaction per fired slot in slot order,
// with last on the final one, or a single done result when nothing fired. All
// slots read as inactive after reset, with no clearing pass.
module periodic_event_timer_table #(
    parameter int SLOT_COUNT = pet_pkg::SLOT_COUNT_DEF,
    parameter int ID_BITS    = pet_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pet_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pet_pkg::t_out_item  o_out_data
);

    localparam int AddrW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    pet_pkg::t_cmd    cmd;
    pet_pkg::t_stat   stat;
    logic [AddrW-1:0] rd_addr;
    logic [AddrW-1:0] eval_idx;

    // sequencer
    pet_controller #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_eval_idx (eval_idx)
    );

    // slot table and result formatting
    pet_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_eval_idx  (eval_idx),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== test/periodic_event_timer_table_test.sv =====
`timescale 1ns / 100ps

module periodic_event_timer_table_test;

    import pet_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 200;
    localparam int QUIET_FROM = 160;
    localparam int DRAIN_AT = 100;
    localparam int SETTLE_CYCLES = 40;

    // op codes the block does not define
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // tracks slot contents and the results each transaction must produce
    class timer_table_tracker;
        logic [15:0]           countdown [SLOTS];
        logic [15:0]           reload_ivl[SLOTS];
        logic [ID_FIELD_W-1:0] slot_id   [SLOTS];
        t_out_item             awaited_results[$];
        int                    n_errors;

        function new();
            clear_table();
            n_errors = 0;
        endfunction

        function void clear_table();
            for (int i = 0; i < SLOTS; i++) begin
                countdown[i]  = CD_INACTIVE;
                reload_ivl[i] = '0;
                slot_id[i]    = '0;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void push_result(logic [2:0] status, logic [ID_FIELD_W-1:0] id,
                                  int slot, logic last);
            t_out_item r;
            r.status   = status;
            r.fired_id = id;
            r.slot     = 4'(slot);
            r.last     = last;
            awaited_results.push_back(r);
        endfunction

        // update the table for one accepted transaction and queue its results
        function void apply_request(t_in_item it);
            logic [15:0] ivl;
            bit          done;
            int          n_fired;
            done    = 1'b0;
            n_fired = 0;
            case (it.op)
                OP_ACTIVATE: begin
                    if (it.event_id == '0) begin
                        push_result(ST_NULL, '0, 0, 1'b1);
                    end else begin
                        ivl = it.interval;
                        if (ivl == 16'd0) ivl = 16'd1;
                        if (ivl == CD_INACTIVE) ivl = IVL_MAX;
                        // refresh an active slot that already holds the id
                        for (int i = 0; i < SLOTS && !done; i++) begin
                            if (countdown[i] != CD_INACTIVE && slot_id[i] == it.event_id) begin
                                countdown[i]  = ivl;
                                reload_ivl[i] = ivl;
                                push_result(ST_REFRESHED, it.event_id, i, 1'b1);
                                done = 1'b1;
                            end
                        end
                        // otherwise take the first free slot
                        for (int i = 0; i < SLOTS && !done; i++) begin
                            if (countdown[i] == CD_INACTIVE) begin
                                countdown[i]  = ivl;
                                reload_ivl[i] = ivl;
                                slot_id[i]    = it.event_id;
                                push_result(ST_ADDED, it.event_id, i, 1'b1);
                                done = 1'b1;
                            end
                        end
                        if (!done) push_result(ST_FULL, it.event_id, 0, 1'b1);
                    end
                end
                OP_CANCEL: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_id[i] == it.event_id) begin
                            countdown[i] = CD_INACTIVE;
                            slot_id[i]   = '0;
                        end
                    end
                    push_result(ST_DONE, it.event_id, 0, 1'b1);
                end
                OP_CANCEL_ALL: begin
                    clear_table();
                    push_result(ST_DONE, '0, 0, 1'b1);
                end
                OP_TICK: begin
                    // expired slots hold at zero until serviced
                    for (int i = 0; i < SLOTS; i++) begin
                        if (countdown[i] != CD_INACTIVE && countdown[i] != 16'd0)
                            countdown[i] = countdown[i] - 16'd1;
                    end
                    push_result(ST_DONE, '0, 0, 1'b1);
                end
                OP_SERVICE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (countdown[i] == 16'd0) begin
                            countdown[i] = reload_ivl[i];
                            if (slot_id[i] != '0) begin
                                push_result(ST_FIRED, slot_id[i], i, 1'b0);
                                n_fired++;
                            end
                        end
                    end
                    if (n_fired == 0)
                        push_result(ST_DONE, '0, 0, 1'b1);
                    else
                        awaited_results[awaited_results.size() - 1].last = 1'b1;
                end
                default: begin
                    push_result(ST_DONE, '0, 0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(input string what);
            if (n_errors < 50) $display("mismatch: %s", what);
            n_errors++;
        endtask

        // compare one output transaction against the oldest awaited result
        task match_result(input t_out_item got);
            t_out_item exp;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d id=%0d slot=%0d last=%0d",
                                          got.status, got.fired_id, got.slot, got.last));
                return;
            end
            exp = awaited_results.pop_front();
            if (got.status !== exp.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, exp.status));
            if (got.fired_id !== exp.fired_id)
                report_mismatch($sformatf("fired_id got %0d want %0d",
                                          got.fired_id, exp.fired_id));
            if (got.slot !== exp.slot)
                report_mismatch($sformatf("slot got %0d want %0d", got.slot, exp.slot));
            if (got.last !== exp.last)
                report_mismatch($sformatf("last got %0d want %0d", got.last, exp.last));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    timer_table_tracker tracker;
    bit quiet_phase = 1'b0;
    int rx_hold     = 0;
    int cycle_count = 0;

    periodic_event_timer_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.match_result(o_out_data);
        if (rx_hold > 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rx_hold     <= $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_in_item mk(logic [2:0] op, logic [ID_FIELD_W-1:0] id,
                                    logic [15:0] ivl);
        t_in_item it;
        it.op       = op;
        it.event_id = id;
        it.interval = ivl;
        return it;
    endfunction

    // mostly a small pool so ids collide, refresh and fill the table
    function automatic logic [ID_FIELD_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 85) return ID_FIELD_W'($urandom_range(1, 14));
        return ID_FIELD_W'($urandom_range(0, 255));
    endfunction

    function automatic t_in_item random_item();
        int          r;
        logic [15:0] ivl;
        r = $urandom_range(0, 99);
        // short intervals so slots actually expire
        if ($urandom_range(0, 9) < 7)      ivl = 16'($urandom_range(0, 4));
        else if ($urandom_range(0, 1) == 0) ivl = 16'($urandom_range(5, 20));
        else                                ivl = 16'($urandom);
        if (r < 35) return mk(OP_ACTIVATE, pick_id(), ivl);
        if (r < 45) return mk(OP_CANCEL, pick_id(), 16'($urandom));
        if (r < 47) return mk(OP_CANCEL_ALL, ID_FIELD_W'($urandom), 16'($urandom));
        if (r < 72) return mk(OP_TICK, ID_FIELD_W'($urandom), 16'($urandom));
        if (r < 93) return mk(OP_SERVICE, ID_FIELD_W'($urandom), 16'($urandom));
        if (r < 96)
            return mk(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                      ID_FIELD_W'($urandom), 16'($urandom));
        return mk(OP_ACTIVATE, '0, 16'($urandom));
    endfunction

    // send one transaction, then optionally idle or wait for the block to drain
    task automatic issue(input t_in_item it, input bit drain);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.apply_request(it);
        if (drain) begin
            i_in_valid <= 1'b0;
            while (tracker.pending() != 0) @(posedge i_clk);
        end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_in_item it;
        int       counted;
        tracker = new();
        counted = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, null id, interval extremes, full table, cancels
        issue(mk(OP_SERVICE, '0, '0), 1'b0);
        issue(mk(OP_ACTIVATE, '0, 16'd5), 1'b0);
        issue(mk(OP_ACTIVATE, 8'd5, 16'd0), 1'b0);
        issue(mk(OP_TICK, '0, '0), 1'b0);
        issue(mk(OP_SERVICE, '0, '0), 1'b0);
        issue(mk(OP_ACTIVATE, 8'd5, 16'hFFFF), 1'b0);
        issue(mk(OP_ACTIVATE, 8'd255, 16'hFFFE), 1'b0);
        for (int i = 1; i <= 10; i++)
            issue(mk(OP_ACTIVATE, ID_FIELD_W'(i), 16'd2), 1'b0);
        issue(mk(OP_ACTIVATE, 8'd77, 16'd3), 1'b0);
        issue(mk(OP_TICK, '0, '0), 1'b0);
        issue(mk(OP_TICK, '0, '0), 1'b0);
        issue(mk(OP_SERVICE, '0, '0), 1'b0);
        issue(mk(OP_CANCEL, 8'd3, '0), 1'b0);
        issue(mk(OP_CANCEL, '0, '0), 1'b0);
        issue(mk(OP_UNUSED_HI, 8'hFF, 16'hFFFF), 1'b0);
        issue(mk(OP_CANCEL_ALL, '0, '0), 1'b0);

        // random traffic; unknown ops do not count toward the total
        while (counted < RANDOM_ITEMS) begin
            it = random_item();
            if (it.op <= OP_SERVICE) counted++;
            if (counted >= QUIET_FROM) quiet_phase = 1'b1;
            issue(it, counted == DRAIN_AT && it.op <= OP_SERVICE);
        end
        i_in_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pet_pkg.sv
rtl/core/pet_controller.sv
rtl/core/pet_datapath.sv
rtl/core/periodic_event_timer_table.sv
test/periodic_event_timer_table_test.sv
